[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, held off during reset
`define TCPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A result word that is stalled keeps the given signal
`define TCPQ_ASSERT_HOLD(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        out_valid && out_stall |=> $stable(sig)) else $error(msg);

`endif

[rtl/tcpq_pkg.sv]
// Shared constants and types of the three-class priority queue.
// Depends on nothing.
package tcpq_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int NUM_CLASSES = 3;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Class codes
    localparam logic [1:0] CLS_URGENT   = 2'd0;
    localparam logic [1:0] CLS_STANDARD = 2'd1;
    localparam logic [1:0] CLS_ECONOMY  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Result information that travels beside the store read
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] cls;
    } tcpq_meta_t;

endpackage

[rtl/tcpq_store.sv]
// Entry store: single-port-write, registered-read memory of item words.
// Depends on nothing.
module tcpq_store #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tcpq_ctrl.sv]
// Ring pointers and fill counts of the three classes; decides each word.
// Depends on tcpq_pkg.
module tcpq_ctrl #(
    parameter int SLOTS_PER_CLASS = tcpq_pkg::SLOTS_DEF,
    parameter int AW              = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic                cmd,
    input  logic [1:0]          service_class,
    input  logic [15:0]         item_handle,
    input  logic [15:0]         dest_handle,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output logic [31:0]         wdata,
    output logic                re,
    output logic [AW-1:0]       raddr,
    output tcpq_pkg::tcpq_meta_t meta
);

    localparam int NC = tcpq_pkg::NUM_CLASSES;
    localparam int PW = $clog2(SLOTS_PER_CLASS);
    localparam int FW = $clog2(SLOTS_PER_CLASS + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(SLOTS_PER_CLASS - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(SLOTS_PER_CLASS);

    logic [PW-1:0] head_reg [NC];
    logic [PW-1:0] tail_reg [NC];
    logic [FW-1:0] fill_reg [NC];
    logic [PW-1:0] head_next [NC];
    logic [PW-1:0] tail_next [NC];
    logic [FW-1:0] fill_next [NC];

    logic [1:0]    ins_cls;
    logic          ins_full;
    logic          pop_any;
    logic [1:0]    pop_cls;
    logic          ins_go;
    logic          pop_go;
    logic [PW-1:0] tail_cur;
    logic [PW-1:0] head_cur;

    // Class code three counts as economy
    assign ins_cls  = (service_class == 2'd3) ? tcpq_pkg::CLS_ECONOMY : service_class;
    assign tail_cur = tail_reg[ins_cls];
    assign ins_full = (fill_reg[ins_cls] == FILL_MAX);

    // Most urgent class that holds an item
    always_comb
    begin
        pop_any = 1'b1;
        pop_cls = tcpq_pkg::CLS_URGENT;
        priority if (fill_reg[0] != '0)
        begin
            pop_cls = tcpq_pkg::CLS_URGENT;
        end
        else if (fill_reg[1] != '0)
        begin
            pop_cls = tcpq_pkg::CLS_STANDARD;
        end
        else if (fill_reg[2] != '0)
        begin
            pop_cls = tcpq_pkg::CLS_ECONOMY;
        end
        else
        begin
            pop_any = 1'b0;
        end
    end

    assign head_cur = head_reg[pop_cls];
    assign ins_go   = go && (cmd == tcpq_pkg::CMD_INSERT) && !ins_full;
    assign pop_go   = go && (cmd == tcpq_pkg::CMD_POP) && pop_any;

    // Store access: append at tail, read at head
    assign we    = ins_go;
    assign waddr = AW'(ins_cls) * AW'(SLOTS_PER_CLASS) + AW'(tail_cur);
    assign wdata = {item_handle, dest_handle};
    assign re    = pop_go;
    assign raddr = AW'(pop_cls) * AW'(SLOTS_PER_CLASS) + AW'(head_cur);

    // Status of this word
    always_comb
    begin
        meta.cls = '0;
        if (cmd == tcpq_pkg::CMD_INSERT)
        begin
            meta.status = ins_full ? tcpq_pkg::ST_FULL : tcpq_pkg::ST_INSERTED;
        end
        else if (pop_any)
        begin
            meta.status = tcpq_pkg::ST_POPPED;
            meta.cls    = pop_cls;
        end
        else
        begin
            meta.status = tcpq_pkg::ST_EMPTY;
        end
    end

    // Pointer and count updates, one class per word
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            fill_next[c] = fill_reg[c];
            if (ins_go && (ins_cls == 2'(c)))
            begin
                tail_next[c] = (tail_reg[c] == PTR_LAST) ? '0 : tail_reg[c] + 1'b1;
                fill_next[c] = fill_reg[c] + 1'b1;
            end
            if (pop_go && (pop_cls == 2'(c)))
            begin
                head_next[c] = (head_reg[c] == PTR_LAST) ? '0 : head_reg[c] + 1'b1;
                fill_next[c] = fill_reg[c] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NC; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                fill_reg[c] <= fill_next[c];
            end
        end
    end

endmodule

[rtl/three_class_priority_queue.sv]
// Top level of the three-class strict-priority queue.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_store.
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | cmd, service_class, item_handle, dest_handle
//  output  | out_valid / out_stall| status, out_class, out_item, out_dest
//
// One word a cycle unless the input stalls. The store read and status are registered
// into stage one when a word is taken, and into the output registers once it moves on.
// Each word makes at most one store access, so the store port does not limit the rate.
// Reset clears pointers and fill counts at once; the store itself is not cleared.
// Stalled results hold; input stalls only when both stages are full and output stalls.
module three_class_priority_queue #(
    parameter int SLOTS_PER_CLASS = tcpq_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [1:0]  service_class,
    input  logic [15:0] item_handle,
    input  logic [15:0] dest_handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [1:0]  out_class,
    output logic [15:0] out_item,
    output logic [15:0] out_dest
);

    localparam int DEPTH = tcpq_pkg::NUM_CLASSES * SLOTS_PER_CLASS;
    localparam int AW    = $clog2(DEPTH);

    logic                 go;
    logic                 we;
    logic                 re;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [31:0]          wdata;
    logic [31:0]          rdata;
    tcpq_pkg::tcpq_meta_t meta;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    tcpq_pkg::tcpq_meta_t s1_meta_reg;
    logic                 s1_adv;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           class_reg;
    logic [15:0]          item_reg;
    logic [15:0]          dest_reg;
    logic                 popped;

    // Handshake: stage one moves on unless the output word is stalled
    assign s1_adv   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign go       = in_valid && !in_stall;

    tcpq_ctrl #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .AW              (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .cmd           (cmd),
        .service_class (service_class),
        .item_handle   (item_handle),
        .dest_handle   (dest_handle),
        .we            (we),
        .waddr         (waddr),
        .wdata         (wdata),
        .re            (re),
        .raddr         (raddr),
        .meta          (meta)
    );

    tcpq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Stage valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (go)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one payload: status beside the store read
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_meta_reg <= meta;
        end
    end

    // Output word; handles are zero unless an item was popped
    assign popped = (s1_meta_reg.status == tcpq_pkg::ST_POPPED);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg <= s1_meta_reg.status;
            class_reg  <= s1_meta_reg.cls;
            item_reg   <= popped ? rdata[31:16] : 16'd0;
            dest_reg   <= popped ? rdata[15:0] : 16'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_class = class_reg;
    assign out_item  = item_reg;
    assign out_dest  = dest_reg;

endmodule

[rtl/tcpq_checker.sv]
// Port-level checks of the three-class priority queue, bound to the top level.
// Depends on tcpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcpq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        cmd,
    input logic [1:0]  service_class,
    input logic [15:0] item_handle,
    input logic [15:0] dest_handle,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [1:0]  out_class,
    input logic [15:0] out_item,
    input logic [15:0] out_dest
);

    // A stalled result word stays put
    `TCPQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result word dropped while stalled")
    `TCPQ_ASSERT_HOLD(a_status_hold, status, "status changed while stalled")

    // Only a popped word carries class and handles
    `TCPQ_ASSERT(a_zero_fields, out_valid && (status != tcpq_pkg::ST_POPPED) |-> (out_class == 2'd0) && (out_item == 16'd0) && (out_dest == 16'd0), "non-pop word has payload")

    // A popped class is a real class
    `TCPQ_ASSERT(a_pop_class, out_valid && (status == tcpq_pkg::ST_POPPED) |-> (out_class != 2'd3), "popped word names no class")

    // Input is only held back while a result word is pending
    `TCPQ_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with output free")

endmodule

bind three_class_priority_queue tcpq_checker u_tcpq_checker (.*);

[tb/tb_three_class_priority_queue.sv]
// Self-checking testbench for the three-class strict-priority queue.
// Depends on tcpq_pkg and three_class_priority_queue; a ring model of each class
// predicts every result, first from a directed table and then from random traffic.
module tb_three_class_priority_queue;

    localparam int SLOTS      = tcpq_pkg::SLOTS_DEF;
    localparam int NCLS       = tcpq_pkg::NUM_CLASSES;
    localparam int PTR_W      = $clog2(SLOTS);
    localparam int FILL_W     = $clog2(SLOTS + 1);
    localparam int QUIET_MAX  = 2000;
    localparam int PLAN_LEN   = 12;
    localparam int SEGMENTS   = 8;
    localparam int SEG_WORDS  = 50;
    localparam int IDLE_PCT   = 23;

    // Class code three is folded into economy; zero stands in unused result fields
    localparam logic [1:0] CLS_THREE = 2'd3;
    localparam logic [1:0] NO_CLASS  = 2'd0;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  cls;
        logic [15:0] item;
        logic [15:0] dest;
    } result_t;

    // One directed row; reps repeats the row with the item handle counting up
    typedef struct packed {
        logic        op;
        logic [1:0]  cls;
        logic [15:0] item;
        logic [15:0] dest;
        logic [4:0]  reps;
        logic        typed;
        result_t     want;
    } row_t;

    localparam result_t RES_NONE     = '0;
    localparam result_t RES_INSERTED =
        '{tcpq_pkg::ST_INSERTED, NO_CLASS, 16'h0000, 16'h0000};
    localparam result_t RES_EMPTY    =
        '{tcpq_pkg::ST_EMPTY, NO_CLASS, 16'h0000, 16'h0000};
    localparam result_t RES_FULL     =
        '{tcpq_pkg::ST_FULL, NO_CLASS, 16'h0000, 16'h0000};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [1:0]  service_class;
    logic [15:0] item_handle;
    logic [15:0] dest_handle;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [1:0]  out_class;
    logic [15:0] out_item;
    logic [15:0] out_dest;

    // No idling on either side while calm is set
    logic calm = 1'b0;

    // Ring model of the three classes
    logic [31:0]       ring_word [NCLS * SLOTS];
    logic [PTR_W-1:0]  ring_rd   [NCLS];
    logic [PTR_W-1:0]  ring_wr   [NCLS];
    logic [FILL_W-1:0] ring_fill [NCLS];

    result_t pending [$];
    int      errors;
    int      n_insert;
    int      n_drop;
    int      n_popped;
    int      n_empty;
    int      popped_by_class [NCLS];

    three_class_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .service_class (service_class),
        .item_handle   (item_handle),
        .dest_handle   (dest_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_class     (out_class),
        .out_item      (out_item),
        .out_dest      (out_dest)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] p);
        return (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Apply one command word to the ring model and return the result it gives
    function automatic result_t queue_apply(logic op, logic [1:0] cls_in,
                                            logic [15:0] item, logic [15:0] dest);
        result_t    r;
        logic [1:0] c;
        logic [31:0] w;
        r = RES_NONE;
        if (op == tcpq_pkg::CMD_INSERT)
        begin
            c = (cls_in > tcpq_pkg::CLS_ECONOMY) ? tcpq_pkg::CLS_ECONOMY : cls_in;
            if (ring_fill[c] >= FILL_W'(SLOTS))
            begin
                r.status = tcpq_pkg::ST_FULL;
                n_drop++;
            end
            else
            begin
                ring_word[c * SLOTS + ring_wr[c]] = {item, dest};
                ring_wr[c]   = ring_advance(ring_wr[c]);
                ring_fill[c] = ring_fill[c] + 1'b1;
                r.status = tcpq_pkg::ST_INSERTED;
                n_insert++;
            end
            return r;
        end
        // Pop: most urgent non-empty class wins
        for (int k = 0; k < NCLS; k++)
        begin
            if (ring_fill[k] != 0)
            begin
                w = ring_word[k * SLOTS + ring_rd[k]];
                ring_rd[k]   = ring_advance(ring_rd[k]);
                ring_fill[k] = ring_fill[k] - 1'b1;
                r.status = tcpq_pkg::ST_POPPED;
                r.cls    = 2'(k);
                r.item   = w[31:16];
                r.dest   = w[15:0];
                n_popped++;
                popped_by_class[k]++;
                return r;
            end
        end
        r.status = tcpq_pkg::ST_EMPTY;
        n_empty++;
        return r;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Offer one word, idling first at random, and return once it is taken
    task automatic send_word(input logic op, input logic [1:0] cls_in,
                             input logic [15:0] item, input logic [15:0] dest);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        service_class <= cls_in;
        item_handle   <= item;
        dest_handle   <= dest;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending.size() != 0);
    endtask

    // Receiver: random stall except during the calm stretch
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
                report_error($sformatf("result word with nothing expected: status %0d",
                                       status));
            else
            begin
                want = pending.pop_front();
                if (status !== want.status)
                    report_error($sformatf("status %0d, expected %0d",
                                           status, want.status));
                if (out_class !== want.cls)
                    report_error($sformatf("out_class %0d, expected %0d",
                                           out_class, want.cls));
                if (out_item !== want.item)
                    report_error($sformatf("out_item %h, expected %h",
                                           out_item, want.item));
                if (out_dest !== want.dest)
                    report_error($sformatf("out_dest %h, expected %h",
                                           out_dest, want.dest));
            end
        end
    end

    // Watchdog: too long with no word taken on either side ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no progress for %0d cycles", $time, QUIET_MAX);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        row_t       plan [PLAN_LEN];
        result_t    r;
        int         insert_pct [SEGMENTS];
        logic       op;
        logic [15:0] item;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = tcpq_pkg::CMD_INSERT;
        service_class = tcpq_pkg::CLS_URGENT;
        item_handle   = '0;
        dest_handle   = '0;
        errors        = 0;
        n_insert      = 0;
        n_drop        = 0;
        n_popped      = 0;
        n_empty       = 0;
        for (int k = 0; k < NCLS; k++)
        begin
            ring_rd[k]         = '0;
            ring_wr[k]         = '0;
            ring_fill[k]       = '0;
            popped_by_class[k] = 0;
        end

        // Directed: empty pop, class order, class three as economy, full class
        plan = '{
            '{tcpq_pkg::CMD_POP, CLS_THREE, 16'hFFFF, 16'hFFFF, 5'd1, 1'b1,
              RES_EMPTY},
            '{tcpq_pkg::CMD_INSERT, tcpq_pkg::CLS_URGENT, 16'hFFFF, 16'h0000,
              5'd1, 1'b1, RES_INSERTED},
            '{tcpq_pkg::CMD_INSERT, tcpq_pkg::CLS_STANDARD, 16'h0000, 16'hFFFF,
              5'd1, 1'b1, RES_INSERTED},
            '{tcpq_pkg::CMD_INSERT, CLS_THREE, 16'h1234, 16'h8765, 5'd1, 1'b1,
              RES_INSERTED},
            '{tcpq_pkg::CMD_POP, tcpq_pkg::CLS_ECONOMY, 16'h0000, 16'h0000,
              5'd1, 1'b1,
              '{tcpq_pkg::ST_POPPED, tcpq_pkg::CLS_URGENT, 16'hFFFF, 16'h0000}},
            '{tcpq_pkg::CMD_POP, tcpq_pkg::CLS_URGENT, 16'h0000, 16'h0000,
              5'd1, 1'b1,
              '{tcpq_pkg::ST_POPPED, tcpq_pkg::CLS_STANDARD, 16'h0000, 16'hFFFF}},
            '{tcpq_pkg::CMD_POP, tcpq_pkg::CLS_URGENT, 16'h0000, 16'h0000,
              5'd1, 1'b1,
              '{tcpq_pkg::ST_POPPED, tcpq_pkg::CLS_ECONOMY, 16'h1234, 16'h8765}},
            '{tcpq_pkg::CMD_POP, tcpq_pkg::CLS_URGENT, 16'h0000, 16'h0000,
              5'd1, 1'b1, RES_EMPTY},
            '{tcpq_pkg::CMD_INSERT, tcpq_pkg::CLS_URGENT, 16'h0100, 16'h8000,
              5'd16, 1'b0, RES_NONE},
            '{tcpq_pkg::CMD_INSERT, tcpq_pkg::CLS_URGENT, 16'hFFFF, 16'hFFFF,
              5'd1, 1'b1, RES_FULL},
            '{tcpq_pkg::CMD_INSERT, tcpq_pkg::CLS_ECONOMY, 16'h5A5A, 16'hA5A5,
              5'd1, 1'b0, RES_NONE},
            '{tcpq_pkg::CMD_POP, tcpq_pkg::CLS_ECONOMY, 16'h0000, 16'h0000,
              5'd1, 1'b0, RES_NONE}
        };
        // Insert share per random segment: swings between filling and draining
        insert_pct = '{85, 30, 70, 15, 90, 50, 20, 60};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            for (int k = 0; k < plan[i].reps; k++)
            begin
                item = plan[i].item + 16'(k);
                send_word(plan[i].op, plan[i].cls, item, plan[i].dest);
                r = queue_apply(plan[i].op, plan[i].cls, item, plan[i].dest);
                pending.push_back(plan[i].typed ? plan[i].want : r);
            end
        end

        // Hold the sender until the directed results are all back
        drain_results();

        // Random traffic in segments; one segment runs with no idling at all
        for (int s = 0; s < SEGMENTS; s++)
        begin
            calm <= (s == 3);
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                op = ($urandom_range(99) < insert_pct[s]) ?
                     tcpq_pkg::CMD_INSERT : tcpq_pkg::CMD_POP;
                send_word(op, 2'($urandom_range(3)), 16'($urandom), 16'($urandom));
                r = queue_apply(cmd, service_class, item_handle, dest_handle);
                pending.push_back(r);
            end
        end
        calm <= 1'b0;

        // Let the last results out, then keep watching for strays
        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d inserts (%0d dropped on a full class) and %0d pops (%0d on empty)",
                 n_insert + n_drop, n_drop, n_popped + n_empty, n_empty);
        $display("Popped per class: urgent %0d, standard %0d, economy %0d",
                 popped_by_class[0], popped_by_class[1], popped_by_class[2]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
